### rtl/core/lmph_pkg.sv
// Shared constants, types and tables for the level meter with peak hold.
`timescale 1ns / 1ps
`default_nettype none

package lmph_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int NEEDLE_BITS = SAMPLE_BITS - 1;
    localparam int BAR_BITS    = NEEDLE_BITS + 2;
    localparam int PEAK_BITS   = BAR_BITS + 1;
    localparam int AVG_BITS    = 8;
    localparam int COUNT_BITS  = AVG_BITS + 1;
    localparam int SUM_BITS    = NEEDLE_BITS + AVG_BITS;
    localparam int STEP_BITS   = $clog2(SUM_BITS);
    localparam int PIX_BITS    = 4;
    localparam int FALL_BITS   = 8;
    localparam int HOLD_BITS   = 5;
    localparam int HCNT_BITS   = 10;
    localparam int ADDR_BITS   = 4;
    localparam int DATA_BITS   = 32;

    localparam logic [1:0] REG_AVG  = 2'd0;
    localparam logic [1:0] REG_PIX  = 2'd1;
    localparam logic [1:0] REG_FALL = 2'd2;

    localparam logic [AVG_BITS-1:0]  RST_AVG  = AVG_BITS'(0);
    localparam logic [PIX_BITS-1:0]  RST_PIX  = PIX_BITS'(4);
    localparam logic [FALL_BITS-1:0] RST_FALL = FALL_BITS'(3);
    localparam logic [HOLD_BITS-1:0] RST_HOLD = HOLD_BITS'(30);
    localparam logic [PIX_BITS-1:0]  MAX_PIX  = PIX_BITS'(8);

    typedef struct packed {
        logic ndl_en;
        logic peak_en;
    } t_trk_ctrl;

    // 30 / (n + 1)
    function automatic logic [HOLD_BITS-1:0] hold_ticks_of(input logic [AVG_BITS-1:0] n);
        logic [HOLD_BITS-1:0] v;
        begin
            priority if (n == AVG_BITS'(0)) begin
                v = HOLD_BITS'(30);
            end else if (n == AVG_BITS'(1)) begin
                v = HOLD_BITS'(15);
            end else if (n == AVG_BITS'(2)) begin
                v = HOLD_BITS'(10);
            end else if (n == AVG_BITS'(3)) begin
                v = HOLD_BITS'(7);
            end else if (n == AVG_BITS'(4)) begin
                v = HOLD_BITS'(6);
            end else if (n == AVG_BITS'(5)) begin
                v = HOLD_BITS'(5);
            end else if (n == AVG_BITS'(6)) begin
                v = HOLD_BITS'(4);
            end else if (n <= AVG_BITS'(9)) begin
                v = HOLD_BITS'(3);
            end else if (n <= AVG_BITS'(14)) begin
                v = HOLD_BITS'(2);
            end else if (n <= AVG_BITS'(29)) begin
                v = HOLD_BITS'(1);
            end else begin
                v = HOLD_BITS'(0);
            end
            return v;
        end
    endfunction

endpackage

`default_nettype wire

### rtl/core/lmph_div.sv
// Bit-serial restoring divider for the window mean.
`timescale 1ns / 1ps
`default_nettype none

module lmph_div import lmph_pkg::*; (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_start,
    input  wire [SUM_BITS-1:0]     i_dividend,
    input  wire [COUNT_BITS-1:0]   i_divisor,
    output logic [NEEDLE_BITS-1:0] o_quotient,
    output logic                   o_done
);

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_BITS-1:0]  r_cnt;
    logic [SUM_BITS-1:0]   r_quo;
    logic [COUNT_BITS-1:0] r_rem;
    logic [COUNT_BITS-1:0] r_div;

    logic [COUNT_BITS:0]   trial;
    logic [COUNT_BITS:0]   diff;
    logic                  ge;
    logic                  last;

    assign trial = {r_rem, r_quo[SUM_BITS-1]};
    assign ge    = trial >= {1'b0, r_div};
    assign diff  = trial - {1'b0, r_div};
    assign last  = r_cnt == STEP_BITS'(SUM_BITS - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + STEP_BITS'(1);
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[SUM_BITS-2:0], ge};
            r_rem <= ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
        end
    end

    assign o_quotient = r_quo[NEEDLE_BITS-1:0];
    assign o_done     = r_done;

endmodule

`default_nettype wire

### rtl/core/lmph_track.sv
// Needle, bar scale and peak marker state with its two update steps.
`timescale 1ns / 1ps
`default_nettype none

module lmph_track import lmph_pkg::*; (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  t_trk_ctrl                    i_ctrl,
    input  wire [NEEDLE_BITS-1:0]        i_mean,
    input  wire [PIX_BITS-1:0]           i_pixel_step,
    input  wire [FALL_BITS-1:0]          i_fall_interval,
    input  wire [HOLD_BITS-1:0]          i_hold_ticks,
    output logic [BAR_BITS-1:0]          o_bar,
    output logic signed [PEAK_BITS-1:0]  o_peak_next,
    output logic [NEEDLE_BITS-1:0]       o_needle
);

    logic signed [NEEDLE_BITS:0]   r_needle;
    logic [BAR_BITS-1:0]           r_scale;
    logic signed [PEAK_BITS-1:0]   r_peak;
    logic signed [HCNT_BITS-1:0]   r_hcnt;

    logic signed [NEEDLE_BITS:0]   n_needle;
    logic signed [NEEDLE_BITS:0]   ndl_t;
    logic [BAR_BITS-1:0]           n_scale;
    logic signed [PEAK_BITS-1:0]   n_peak;
    logic signed [HCNT_BITS-1:0]   n_hcnt;
    logic signed [PEAK_BITS-1:0]   peak_t;
    logic signed [HCNT_BITS-1:0]   hcnt_t;
    logic signed [PEAK_BITS-1:0]   scale_s;
    logic [PIX_BITS-1:0]           step;

    assign step    = (i_pixel_step > MAX_PIX) ? MAX_PIX : i_pixel_step;
    assign scale_s = $signed({1'b0, r_scale});

    always_comb begin
        ndl_t = (r_needle < $signed({1'b0, i_mean})) ? $signed({1'b0, i_mean})
                                                     : r_needle - (NEEDLE_BITS+1)'(1);
        n_needle = ndl_t[NEEDLE_BITS] ? '0 : ndl_t;
        n_scale  = BAR_BITS'(n_needle[NEEDLE_BITS-1:1] * step);
    end

    always_comb begin
        peak_t = r_peak;
        hcnt_t = r_hcnt;
        if (r_peak < scale_s) begin
            peak_t = scale_s;
            hcnt_t = -$signed({{(HCNT_BITS-HOLD_BITS){1'b0}}, i_hold_ticks});
        end
        if (hcnt_t > $signed({{(HCNT_BITS-FALL_BITS){1'b0}}, i_fall_interval})) begin
            peak_t = peak_t - $signed({{(PEAK_BITS-PIX_BITS){1'b0}}, step});
            hcnt_t = '0;
        end
        n_peak = peak_t;
        n_hcnt = hcnt_t + HCNT_BITS'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_needle <= '1;
            r_scale  <= '0;
            r_peak   <= '0;
            r_hcnt   <= '0;
        end else begin
            if (i_ctrl.ndl_en) begin
                r_needle <= n_needle;
                r_scale  <= n_scale;
            end
            if (i_ctrl.peak_en) begin
                r_peak <= n_peak;
                r_hcnt <= n_hcnt;
            end
        end
    end

    assign o_bar       = r_scale;
    assign o_peak_next = n_peak;
    assign o_needle    = r_needle[NEEDLE_BITS-1:0];

endmodule

`default_nettype wire

### rtl/core/level_meter_peak_hold.sv
// Top level of the level meter with peak hold: registers, window sum, control.
// A request that does not close a window only adds to the window sum; a closing
// request yields its result after the divider shift steps, divider done, the
// needle step and the peak step; the peak step waits while an earlier result is
// not yet taken. Throughput: one request per cycle inside a window; a closing
// request stalls the input until the peak step is done. Reset (synchronous,
// active low) restores register defaults and the meter state.
`timescale 1ns / 1ps
`default_nettype none

module level_meter_peak_hold import lmph_pkg::*; (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire signed [SAMPLE_BITS-1:0] i_sample_level,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic [BAR_BITS-1:0]          o_bar_position,
    output logic signed [PEAK_BITS-1:0]  o_peak_position,
    output logic [NEEDLE_BITS-1:0]       o_needle_level,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [ADDR_BITS-1:0]          paddr,
    input  wire [DATA_BITS-1:0]          pwdata,
    output logic [DATA_BITS-1:0]         prdata,
    output logic                         pready
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_NDL  = 2'd2;
    localparam logic [1:0] S_PEAK = 2'd3;

    logic [1:0]                  r_state;
    logic [1:0]                  n_state;
    logic [AVG_BITS-1:0]         r_avg;
    logic [PIX_BITS-1:0]         r_pix;
    logic [FALL_BITS-1:0]        r_fall;
    logic [HOLD_BITS-1:0]        r_hold;
    logic [SUM_BITS-1:0]         r_sum;
    logic [COUNT_BITS-1:0]       r_cnt;
    logic                        r_out_valid;
    logic [BAR_BITS-1:0]         r_bar;
    logic signed [PEAK_BITS-1:0] r_peak_out;
    logic [NEEDLE_BITS-1:0]      r_needle_out;

    logic                        in_acc;
    logic                        out_take;
    logic                        peak_go;
    logic                        cfg_wr;
    logic [1:0]                  reg_idx;
    logic [NEEDLE_BITS-1:0]      level;
    logic [SUM_BITS-1:0]         n_sum;
    logic [COUNT_BITS-1:0]       n_cnt;
    logic                        win_end;
    logic                        div_done;
    logic [NEEDLE_BITS-1:0]      mean;
    t_trk_ctrl                   trk_ctrl;
    logic [BAR_BITS-1:0]         trk_bar;
    logic signed [PEAK_BITS-1:0] trk_peak;
    logic [NEEDLE_BITS-1:0]      trk_needle;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign reg_idx  = paddr[3:2];

    always_comb begin
        unique case (reg_idx)
            REG_AVG:  prdata = DATA_BITS'(r_avg);
            REG_PIX:  prdata = DATA_BITS'(r_pix);
            REG_FALL: prdata = DATA_BITS'(r_fall);
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg  <= RST_AVG;
            r_pix  <= RST_PIX;
            r_fall <= RST_FALL;
            r_hold <= RST_HOLD;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_AVG: begin
                    r_avg  <= pwdata[AVG_BITS-1:0];
                    r_hold <= hold_ticks_of(pwdata[AVG_BITS-1:0]);
                end
                REG_PIX:  r_pix  <= pwdata[PIX_BITS-1:0];
                REG_FALL: r_fall <= pwdata[FALL_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall = r_state != S_IDLE;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_take   = r_out_valid && !i_out_stall;
    assign peak_go    = (r_state == S_PEAK) && (!r_out_valid || !i_out_stall);

    assign level   = i_sample_level[SAMPLE_BITS-1] ? '0 : i_sample_level[NEEDLE_BITS-1:0];
    assign n_sum   = r_sum + SUM_BITS'(level);
    assign n_cnt   = r_cnt + COUNT_BITS'(1);
    assign win_end = n_cnt > {1'b0, r_avg};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_acc && win_end) begin
                n_state = S_DIV;
            end
            S_DIV: if (div_done) begin
                n_state = S_NDL;
            end
            S_NDL:  n_state = S_PEAK;
            S_PEAK: if (peak_go) begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_sum <= win_end ? '0 : n_sum;
                r_cnt <= win_end ? '0 : n_cnt;
            end
            if (peak_go) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (peak_go) begin
            r_bar        <= trk_bar;
            r_peak_out   <= trk_peak;
            r_needle_out <= trk_needle;
        end
    end

    lmph_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_acc && win_end),
        .i_dividend (n_sum),
        .i_divisor  (n_cnt),
        .o_quotient (mean),
        .o_done     (div_done)
    );

    assign trk_ctrl.ndl_en  = r_state == S_NDL;
    assign trk_ctrl.peak_en = peak_go;

    lmph_track u_track (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (trk_ctrl),
        .i_mean          (mean),
        .i_pixel_step    (r_pix),
        .i_fall_interval (r_fall),
        .i_hold_ticks    (r_hold),
        .o_bar           (trk_bar),
        .o_peak_next     (trk_peak),
        .o_needle        (trk_needle)
    );

    assign o_out_valid     = r_out_valid;
    assign o_bar_position  = r_bar;
    assign o_peak_position = r_peak_out;
    assign o_needle_level  = r_needle_out;

endmodule

`default_nettype wire
